// ===== rtl/dws_pkg.sv =====
// ----------------------------------------------------------------------------
// dws_pkg: shared types and constants for the dual wheel speed controller
// Field widths, register defaults, sequencer steps and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dws_pkg;

  localparam int unsigned RATE_HZ_DEF = 100;

  localparam int unsigned CNT_W      = 16;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned DLIM_W     = 10;
  localparam int unsigned ILIM_W     = 47;
  localparam int unsigned MPP_W      = 16;
  localparam int unsigned SPDF_W     = 20;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned ERR_W      = 40;
  localparam int unsigned INTEG_W    = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 47;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 96;

  // Shared multiplier and accumulator sizes; cover the whole rate range
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 24;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = 80;
  localparam int unsigned SPD_W   = 48;
  localparam int unsigned DR_W    = 56;

  // Register defaults
  localparam logic [GAIN_W-1:0] KP_RST   = 24'd32768;
  localparam logic [GAIN_W-1:0] KI_RST   = 24'd6554;
  localparam logic [GAIN_W-1:0] KD_RST   = 24'd1311;
  localparam logic [DLIM_W-1:0] DLIM_RST = 10'd999;
  localparam logic [ILIM_W-1:0] ILIM_RST = 47'd655360000;
  localparam logic [MPP_W-1:0]  MPP_RST  = 16'd8579;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP   = 3'd0,
    CFG_KI   = 3'd1,
    CFG_KD   = 3'd2,
    CFG_DLIM = 3'd3,
    CFG_ILIM = 3'd4,
    CFG_MPP  = 3'd5
  } dws_cfg_e;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_MPPR  = 12'b0000_0000_0010,
    ST_SPEED = 12'b0000_0000_0100,
    ST_ERR   = 12'b0000_0000_1000,
    ST_DIV   = 12'b0000_0001_0000,
    ST_INTEG = 12'b0000_0010_0000,
    ST_MLO   = 12'b0000_0100_0000,
    ST_MHI   = 12'b0000_1000_0000,
    ST_MADD  = 12'b0001_0000_0000,
    ST_SUM   = 12'b0010_0000_0000,
    ST_DIST  = 12'b0100_0000_0000,
    ST_WB    = 12'b1000_0000_0000
  } dws_step_e;

  // Product term under work in the multiply steps
  typedef enum logic [1:0] {
    T_P  = 2'd0,
    T_I  = 2'd1,
    T_DR = 2'd2,
    T_D  = 2'd3
  } dws_term_e;

  typedef struct packed {
    dws_step_e step;
    logic      wheel;
    dws_term_e term;
    logic      accept;
    logic      load;
  } dws_cmd_t;

  typedef struct packed {
    logic div_done;
  } dws_sts_t;

endpackage

// ===== rtl/dws_div.sv =====
// ----------------------------------------------------------------------------
// dws_div: divider by a constant
// Unsigned dividend times a precomputed reciprocal, built from four partial
// products; the quotient is the top of the product.
// ----------------------------------------------------------------------------
module dws_div #(
  parameter int unsigned DIVISOR = 100,
  parameter int unsigned DVD_W   = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dvd_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quo_o
);

  // Reciprocal ceil(2^SHIFT / DIVISOR), exact for every dividend below 2^DVD_W
  localparam int unsigned SHIFT = DVD_W + $clog2(DIVISOR);
  localparam int unsigned M_W   = DVD_W + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [M_W-1:0] RECIP_C = M_W'(RECIP);

  localparam int unsigned XL_W  = DVD_W / 2;
  localparam int unsigned XH_W  = DVD_W - XL_W;
  localparam int unsigned ML_W  = (M_W + 1) / 2;
  localparam int unsigned MH_W  = M_W - ML_W;
  localparam int unsigned PP_W  = XH_W + ML_W;
  localparam int unsigned ACC_W = DVD_W + M_W;

  logic [DVD_W-1:0] x_q;
  logic [ACC_W-1:0] acc_q;
  logic [1:0]       cnt_q;
  logic             busy_q;
  logic [XH_W-1:0]  opa;
  logic [ML_W-1:0]  opb;
  logic [PP_W-1:0]  pp;
  logic [ACC_W-1:0] term;

  // Pick one partial product per cycle and align it
  always_comb begin
    case (cnt_q)
      2'd0: begin
        opa = XH_W'(x_q[XL_W-1:0]);
        opb = RECIP_C[ML_W-1:0];
      end
      2'd1: begin
        opa = x_q[DVD_W-1:XL_W];
        opb = RECIP_C[ML_W-1:0];
      end
      2'd2: begin
        opa = XH_W'(x_q[XL_W-1:0]);
        opb = ML_W'(RECIP_C[M_W-1:ML_W]);
      end
      default: begin
        opa = x_q[DVD_W-1:XL_W];
        opb = ML_W'(RECIP_C[M_W-1:ML_W]);
      end
    endcase
    pp = {{ML_W{1'b0}}, opa} * {{XH_W{1'b0}}, opb};
    case (cnt_q)
      2'd0:    term = ACC_W'(pp);
      2'd1:    term = ACC_W'(pp) << XL_W;
      2'd2:    term = ACC_W'(pp) << ML_W;
      default: term = ACC_W'(pp) << (XL_W + ML_W);
    endcase
  end

  assign done_o = busy_q && (cnt_q == 2'd3);
  assign quo_o  = DVD_W'(acc_q >> SHIFT);

  // Track the partial product count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (done_o) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Hold the dividend and accumulate the product
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= dvd_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + term;
    end
  end

endmodule

// ===== rtl/dws_ctrl.sv =====
// ----------------------------------------------------------------------------
// dws_ctrl: sequencer for the dual wheel speed controller
// Walks both wheels through speed, error, divide, integral and gain products,
// then the distance step, and owns the input and result handshakes.
// ----------------------------------------------------------------------------
module dws_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dws_pkg::dws_cmd_t cmd_o,
  input  dws_pkg::dws_sts_t sts_i
);
  import dws_pkg::*;

  dws_step_e state_q, state_d;
  dws_term_e term_q, term_d;
  logic      wheel_q, wheel_d;
  logic      valid_q, valid_d;

  // Next state and command decode
  always_comb begin
    state_d      = state_q;
    term_d       = term_q;
    wheel_d      = wheel_q;
    cmd_o.step   = state_q;
    cmd_o.wheel  = wheel_q;
    cmd_o.term   = term_q;
    cmd_o.accept = 1'b0;
    cmd_o.load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          wheel_d      = 1'b0;
          state_d      = ST_MPPR;
        end
      end
      ST_MPPR:  state_d = ST_SPEED;
      ST_SPEED: state_d = ST_ERR;
      ST_ERR:   state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_INTEG;
        end
      end
      ST_INTEG: begin
        term_d  = T_P;
        state_d = ST_MLO;
      end
      ST_MLO:   state_d = ST_MHI;
      ST_MHI:   state_d = ST_MADD;
      ST_MADD: begin
        state_d = ST_MLO;
        case (term_q)
          T_P:     term_d = T_I;
          T_I:     term_d = T_DR;
          T_DR:    term_d = T_D;
          default: state_d = ST_SUM;
        endcase
      end
      ST_SUM: begin
        if (!wheel_q) begin
          wheel_d = 1'b1;
          state_d = ST_SPEED;
        end else begin
          state_d = ST_DIST;
        end
      end
      ST_DIST:  state_d = ST_WB;
      ST_WB: begin
        if (!valid_q || out_ready_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Result beat valid: set on load, drop once taken
  always_comb begin
    valid_d = valid_q;
    if (cmd_o.load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      term_q  <= T_P;
      wheel_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
      wheel_q <= wheel_d;
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = valid_q;

endmodule

// ===== rtl/dws_dp.sv =====
// ----------------------------------------------------------------------------
// dws_dp: datapath for the dual wheel speed controller
// Configuration registers, wheel state, one shared 32x24 multiplier with an
// accumulator, the constant divider and the result register.
// ----------------------------------------------------------------------------
module dws_dp #(
  parameter int unsigned CONTROL_RATE_HZ = dws_pkg::RATE_HZ_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dws_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dws_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [dws_pkg::IN_DATA_W-1:0]      in_data_i,
  input  dws_pkg::dws_cmd_t                  cmd_i,
  output dws_pkg::dws_sts_t                  sts_o,
  output logic [dws_pkg::OUT_DATA_W-1:0]     out_data_o
);
  import dws_pkg::*;

  localparam logic [MUL_B_W-1:0] RATE_B = MUL_B_W'(CONTROL_RATE_HZ);
  localparam logic signed [49:0] ERR_HI = 50'sd549755813887;
  localparam logic signed [49:0] ERR_LO = -ERR_HI - 50'sd1;

  // Configuration
  logic [GAIN_W-1:0] kp_q, ki_q, kd_q;
  logic [DLIM_W-1:0] dlim_q;
  logic [ILIM_W-1:0] ilim_q;
  logic [MPP_W-1:0]  mpp_q;

  // Wheel state
  logic        [CNT_W-1:0]   last_q  [2];
  logic signed [INTEG_W-1:0] integ_q [2];
  logic signed [ERR_W-1:0]   perr_q  [2];
  logic        [DIST_W-1:0]  dist_q;

  // Per item work registers
  logic signed [CNT_W-1:0]  delta_q [2];
  logic signed [CNT_W-1:0]  tgt_q   [2];
  logic        [CNT_W-1:0]  hmag_q;
  logic                     same_q;
  logic        [MUL_A_W-1:0] mppr_q;
  logic        [SPD_W-1:0]  smag_q;
  logic signed [ERR_W-1:0]  err_q;
  logic        [ERR_W-1:0]  emag_q;
  logic        [ILIM_W-1:0] imag_q;
  logic                     ineg_q;
  logic        [ERR_W:0]    dmag_q;
  logic                     dneg_q;
  logic        [DR_W-1:0]   drmag_q;
  logic        [ACC_W-1:0]  acc_q;
  logic signed [63:0]       sum_q;
  logic        [DLIM_W-1:0] duty_q [2];
  logic                     rev_q  [2];
  logic        [SPDF_W-1:0] spdf_q [2];
  logic [OUT_DATA_W-1:0]    od_q;

  logic w;
  assign w = cmd_i.wheel;

  // Accept: wrapped deltas, half sum and travel direction
  logic signed [CNT_W-1:0] dl_n, dr_n;
  logic signed [CNT_W:0]   hsum, half;
  logic [CNT_W-1:0]        hmag_n;
  logic                    same_n;

  always_comb begin
    dl_n   = $signed(in_data_i[15:0] - last_q[0]);
    dr_n   = $signed(in_data_i[31:16] - last_q[1]);
    hsum   = $signed({dl_n[15], dl_n}) + $signed({dr_n[15], dr_n});
    half   = hsum[CNT_W] ? ((hsum + 17'sd1) >>> 1) : (hsum >>> 1);
    hmag_n = half[CNT_W] ? CNT_W'(-half) : half[CNT_W-1:0];
    same_n = (mpp_q != '0) &&
             (((dl_n > 0) && (dr_n > 0)) || ((dl_n < 0) && (dr_n < 0)));
  end

  // Shared multiplier operand select
  logic [CNT_W-1:0]   dabs;
  logic [63:0]        opnd;
  logic [MUL_B_W-1:0] opb;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    dabs = delta_q[w][CNT_W-1] ? CNT_W'(-delta_q[w]) : delta_q[w];
    case (cmd_i.term)
      T_P:     begin opnd = 64'(emag_q);  opb = kp_q;   end
      T_I:     begin opnd = 64'(imag_q);  opb = ki_q;   end
      T_DR:    begin opnd = 64'(dmag_q);  opb = RATE_B; end
      default: begin opnd = 64'(drmag_q); opb = kd_q;   end
    endcase
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.step)
      ST_MPPR:  begin mul_a = MUL_A_W'(mpp_q); mul_b = RATE_B;           end
      ST_SPEED: begin mul_a = mppr_q;          mul_b = MUL_B_W'(dabs);   end
      ST_MLO:   begin mul_a = opnd[31:0];      mul_b = opb;              end
      ST_MHI:   begin mul_a = opnd[63:32];     mul_b = opb;              end
      ST_DIST:  begin mul_a = MUL_A_W'(mpp_q); mul_b = MUL_B_W'(hmag_q); end
      default:  ;
    endcase
    prod = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
  end

  // Error, saturation and speed field
  logic signed [49:0]      spd_s, err_full;
  logic signed [ERR_W-1:0] err_n;
  logic [ERR_W-1:0]        emag_n;
  logic [31:0]             sf_mag;
  logic [SPDF_W-1:0]       spdf_n;

  always_comb begin
    spd_s    = delta_q[w][CNT_W-1] ? -$signed({2'b00, smag_q}) : $signed({2'b00, smag_q});
    err_full = $signed({{18{tgt_q[w][CNT_W-1]}}, tgt_q[w], 16'h0000}) - spd_s;
    if (err_full > ERR_HI) begin
      err_n = ERR_HI[ERR_W-1:0];
    end else if (err_full < ERR_LO) begin
      err_n = ERR_LO[ERR_W-1:0];
    end else begin
      err_n = err_full[ERR_W-1:0];
    end
    emag_n = err_n[ERR_W-1] ? ERR_W'(-err_n) : err_n;
    sf_mag = smag_q[47:16];
    if (delta_q[w][CNT_W-1]) begin
      spdf_n = (sf_mag > 32'd524288) ? 20'h80000 : SPDF_W'(-sf_mag);
    end else begin
      spdf_n = (sf_mag > 32'd524287) ? 20'h7FFFF : sf_mag[SPDF_W-1:0];
    end
  end

  // Error over control rate
  logic [ERR_W-1:0] quo;

  dws_div #(
    .DIVISOR (CONTROL_RATE_HZ),
    .DVD_W   (ERR_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.step == ST_ERR),
    .dvd_i   (emag_n),
    .done_o  (sts_o.div_done),
    .quo_o   (quo)
  );

  // Integral update, clamp and error difference
  logic signed [ERR_W:0] q, derr;
  logic signed [48:0]    isum, lim, icl;
  logic [ILIM_W-1:0]     imag_n;
  logic [ERR_W:0]        dmag_n;

  always_comb begin
    q    = err_q[ERR_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    isum = $signed({integ_q[w][INTEG_W-1], integ_q[w]}) + $signed({{8{q[ERR_W]}}, q});
    lim  = $signed({2'b00, ilim_q});
    if (isum > lim) begin
      icl = lim;
    end else if (isum < -lim) begin
      icl = -lim;
    end else begin
      icl = isum;
    end
    imag_n = icl[48] ? ILIM_W'(-icl) : icl[ILIM_W-1:0];
    derr   = $signed({err_q[ERR_W-1], err_q}) - $signed({perr_q[w][ERR_W-1], perr_q[w]});
    dmag_n = derr[ERR_W] ? (ERR_W + 1)'(-derr) : derr;
  end

  // Signed gain term and output clamp
  logic [63:0]        tmag, tval;
  logic               tneg;
  logic signed [63:0] omax, oc;
  logic [63:0]        omag;
  logic [DLIM_W-1:0]  duty_n;

  always_comb begin
    tmag = acc_q[79:16];
    case (cmd_i.term)
      T_P:     tneg = err_q[ERR_W-1];
      T_I:     tneg = ineg_q;
      default: tneg = dneg_q;
    endcase
    tval = tneg ? -tmag : tmag;
    omax = $signed({38'd0, dlim_q, 16'h0000});
    if (sum_q > omax) begin
      oc = omax;
    end else if (sum_q < -omax) begin
      oc = -omax;
    end else begin
      oc = sum_q;
    end
    omag   = oc[63] ? 64'(-oc) : oc;
    duty_n = omag[25:16];
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= KP_RST;
      ki_q   <= KI_RST;
      kd_q   <= KD_RST;
      dlim_q <= DLIM_RST;
      ilim_q <= ILIM_RST;
      mpp_q  <= MPP_RST;
    end else if (cfg_we_i) begin
      unique case (dws_cfg_e'(cfg_idx_i))
        CFG_KP:   kp_q   <= cfg_wdata_i[GAIN_W-1:0];
        CFG_KI:   ki_q   <= cfg_wdata_i[GAIN_W-1:0];
        CFG_KD:   kd_q   <= cfg_wdata_i[GAIN_W-1:0];
        CFG_DLIM: dlim_q <= cfg_wdata_i[DLIM_W-1:0];
        CFG_ILIM: ilim_q <= cfg_wdata_i[ILIM_W-1:0];
        CFG_MPP:  mpp_q  <= cfg_wdata_i[MPP_W-1:0];
        default:  ;
      endcase
    end
  end

  // Wheel state and distance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q[0]  <= '0;
      last_q[1]  <= '0;
      integ_q[0] <= '0;
      integ_q[1] <= '0;
      perr_q[0]  <= '0;
      perr_q[1]  <= '0;
      dist_q     <= '0;
    end else begin
      if (cmd_i.accept) begin
        last_q[0] <= in_data_i[15:0];
        last_q[1] <= in_data_i[31:16];
      end
      if (cmd_i.step == ST_INTEG) begin
        integ_q[w] <= icl[INTEG_W-1:0];
        perr_q[w]  <= err_q;
      end
      if ((cmd_i.step == ST_DIST) && same_q) begin
        dist_q <= dist_q + DIST_W'(prod[31:16]);
      end
    end
  end

  // Per item work registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      delta_q[0] <= dl_n;
      delta_q[1] <= dr_n;
      tgt_q[0]   <= $signed(in_data_i[47:32]);
      tgt_q[1]   <= $signed(in_data_i[63:48]);
      hmag_q     <= hmag_n;
      same_q     <= same_n;
    end
    unique case (cmd_i.step)
      ST_MPPR:  mppr_q <= prod[MUL_A_W-1:0];
      ST_SPEED: smag_q <= prod[SPD_W-1:0];
      ST_ERR: begin
        err_q     <= err_n;
        emag_q    <= emag_n;
        spdf_q[w] <= spdf_n;
      end
      ST_INTEG: begin
        imag_q <= imag_n;
        ineg_q <= icl[48];
        dmag_q <= dmag_n;
        dneg_q <= derr[ERR_W];
      end
      ST_MLO:   acc_q <= ACC_W'(prod);
      ST_MHI:   acc_q <= acc_q + ACC_W'({prod, 32'h0000_0000});
      ST_MADD: begin
        case (cmd_i.term)
          T_P:     sum_q   <= $signed(tval);
          T_DR:    drmag_q <= acc_q[DR_W-1:0];
          default: sum_q   <= sum_q + $signed(tval);
        endcase
      end
      ST_SUM: begin
        duty_q[w] <= duty_n;
        rev_q[w]  <= oc[63] && (duty_n != '0);
      end
      default:  ;
    endcase
    if (cmd_i.load) begin
      od_q <= {2'b00, dist_q, spdf_q[1], spdf_q[0],
               rev_q[1], duty_q[1], rev_q[0], duty_q[0]};
    end
  end

  assign out_data_o = od_q;

endmodule

// ===== rtl/dual_wheel_speed_pid_top.sv =====
// ----------------------------------------------------------------------------
// dual_wheel_speed_pid_top: two wheel PID speed controller
// Ticks are processed one at a time, held back by the error divide per
//   wheel and the shared multiplier (two partial products per gain term).
// Reset: asynchronous, active low; clears wheel state and distance and loads
//   the register defaults.
// ----------------------------------------------------------------------------
module dual_wheel_speed_pid_top #(
  parameter int unsigned CONTROL_RATE_HZ = dws_pkg::RATE_HZ_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dws_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dws_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // enc_count_left, enc_count_right, target_left, target_right
  input  logic [dws_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // duty_left, reverse_left, duty_right, reverse_right, speed_left,
  // speed_right, travelled_mm, 2 zero bits
  output logic [dws_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import dws_pkg::*;

  dws_cmd_t cmd;
  dws_sts_t sts;

  // Sequencer
  dws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Arithmetic and state
  dws_dp #(
    .CONTROL_RATE_HZ (CONTROL_RATE_HZ)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

// ===== rtl/dws_chk.sv =====
// ----------------------------------------------------------------------------
// dws_chk: port level checks for the dual wheel speed controller
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module dws_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [dws_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // One tick at a time: ready drops after an input beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while a tick is in work");

  // Loading a result frees the input side
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("result loaded while still busy");

  // No result right after an input beat
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("result appeared too early");

endmodule

bind dual_wheel_speed_pid_top dws_chk u_dws_chk (.*);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the dual wheel speed controller
// Drives encoder and target ticks through the input stream, predicts every
// result beat with a local model of the two wheel PIDs and the distance
// counter, and compares each output beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Scoreboard: holds the controller state and the queue of expected beats
class wheel_pid_scoreboard;
  typedef struct packed {
    logic [9:0]  duty_l;
    logic        rev_l;
    logic [9:0]  duty_r;
    logic        rev_r;
    logic [19:0] spd_l;
    logic [19:0] spd_r;
    logic [31:0] dist_mm;
  } tick_result_t;

  bit [23:0]   kp, ki, kd;
  bit [9:0]    dlim;
  bit [46:0]   ilim;
  bit [15:0]   mpp;
  bit [15:0]   last_cnt [2];
  longint      integ [2];
  longint      prev_err [2];
  bit [31:0]   dist_acc;
  tick_result_t pending [$];
  int          n_fail;

  function new();
    kp = 24'd32768; ki = 24'd6554; kd = 24'd1311;
    dlim = 10'd999; ilim = 47'd655360000; mpp = 16'd8579;
    foreach (last_cnt[w]) begin
      last_cnt[w] = '0; integ[w] = 0; prev_err[w] = 0;
    end
    dist_acc = '0;
    n_fail = 0;
  endfunction

  function void write_reg(dws_pkg::dws_cfg_e idx, logic [46:0] val);
    case (idx)
      dws_pkg::CFG_KP:   kp = val[23:0];
      dws_pkg::CFG_KI:   ki = val[23:0];
      dws_pkg::CFG_KD:   kd = val[23:0];
      dws_pkg::CFG_DLIM: dlim = val[9:0];
      dws_pkg::CFG_ILIM: ilim = val;
      dws_pkg::CFG_MPP:  mpp = val[15:0];
      default: ;
    endcase
  endfunction

  // Gain product on the magnitude, shifted by 16, sign put back
  function longint gain_mul(longint a, bit [23:0] g);
    longint m;
    longint r;
    m = (a < 0) ? -a : a;
    r = (m >>> 16) * longint'(g) + (((m & 64'hFFFF) * longint'(g)) >>> 16);
    return (a < 0) ? -r : r;
  endfunction

  function int run_pid(int w, longint target, longint spd);
    longint err, lim, acc, p, i, d, out, omax;
    err = target * 65536 - spd;
    if (err > 64'sd549755813887) err = 64'sd549755813887;
    if (err < -64'sd549755813888) err = -64'sd549755813888;
    lim = longint'(ilim);
    acc = integ[w] + err / 100;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    integ[w] = acc;
    p = gain_mul(err, kp);
    i = gain_mul(acc, ki);
    d = gain_mul((err - prev_err[w]) * 100, kd);
    out = p + i + d;
    omax = longint'(dlim) * 65536;
    if (out > omax) out = omax;
    if (out < -omax) out = -omax;
    prev_err[w] = err;
    return int'(out / 65536);
  endfunction

  function logic [19:0] speed_field(longint spd);
    longint s;
    s = spd / 65536;
    if (s > 524287) s = 524287;
    if (s < -524288) s = -524288;
    return s[19:0];
  endfunction

  // Note an accepted input beat and queue its expected result
  function void note_tick(logic [63:0] beat);
    bit [15:0] cnt [2];
    shortint   dlt [2];
    longint    spd [2];
    int        half, o;
    bit [31:0] mag, stp;
    tick_result_t r;
    cnt[0] = beat[15:0];
    cnt[1] = beat[31:16];
    for (int w = 0; w < 2; w++) begin
      dlt[w] = shortint'(cnt[w] - last_cnt[w]);
      last_cnt[w] = cnt[w];
      spd[w] = longint'(dlt[w]) * longint'(mpp) * 100;
    end
    half = (int'(dlt[0]) + int'(dlt[1])) / 2;
    mag = (half < 0) ? -half : half;
    stp = 32'((longint'(mag) * longint'(mpp)) >> 16);
    if (half < 0) stp = -stp;
    if (spd[0] > 0 && spd[1] > 0) dist_acc += stp;
    else if (spd[0] < 0 && spd[1] < 0) dist_acc -= stp;
    o = run_pid(0, longint'(signed'(beat[47:32])), spd[0]);
    r.duty_l = (o < 0) ? 10'(-o) : 10'(o);
    r.rev_l = o < 0;
    o = run_pid(1, longint'(signed'(beat[63:48])), spd[1]);
    r.duty_r = (o < 0) ? 10'(-o) : 10'(o);
    r.rev_r = o < 0;
    r.spd_l = speed_field(spd[0]);
    r.spd_r = speed_field(spd[1]);
    r.dist_mm = dist_acc;
    pending.push_back(r);
  endfunction

  // Check an accepted result beat against the oldest expectation
  function void check_result(logic [95:0] beat);
    tick_result_t e, a;
    a.duty_l = beat[9:0];
    a.rev_l = beat[10];
    a.duty_r = beat[20:11];
    a.rev_r = beat[21];
    a.spd_l = beat[41:22];
    a.spd_r = beat[61:42];
    a.dist_mm = beat[93:62];
    if (pending.size() == 0) begin
      n_fail++;
      if (n_fail <= 10) $display("unexpected result beat %h", beat);
      return;
    end
    e = pending.pop_front();
    if (e != a || beat[95:94] != 2'b00) begin
      n_fail++;
      if (n_fail <= 10) begin
        $display("mismatch: exp duty %0d/%0d rev %0b/%0b spd %h/%h dist %h",
                 e.duty_l, e.duty_r, e.rev_l, e.rev_r, e.spd_l, e.spd_r, e.dist_mm);
        $display("          got duty %0d/%0d rev %0b/%0b spd %h/%h dist %h",
                 a.duty_l, a.duty_r, a.rev_l, a.rev_r, a.spd_l, a.spd_r, a.dist_mm);
      end
    end
  endfunction
endclass

module tb_top;
  import dws_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  wheel_pid_scoreboard sb;
  int  src_idle_pct;
  int  snk_idle_pct;
  bit  hold_off;
  int  cycle_cnt;
  int  hold_cnt;

  dual_wheel_speed_pid_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_off) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  // Guard against a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Drop the input offer and wait for all expected beats
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (130) @(posedge clk_i);
  endtask

  task automatic write_cfg(dws_cfg_e idx, logic [46:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    sb.write_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one beat, idling first at random; returns after acceptance
  task automatic send_tick(logic [63:0] beat);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= beat;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_tick(beat);
  endtask

  // Mostly well-formed ticks: counters advance by a modest step from the last reading; about one in ten is fully random
  task automatic send_random(int n);
    logic [15:0] t_l, t_r;
    logic [63:0] beat;
    for (int k = 0; k < n; k++) begin
      t_l = 16'(int'($urandom_range(600)) - 300);
      t_r = 16'(int'($urandom_range(600)) - 300);
      if ($urandom_range(9) == 0) begin
        beat = {$urandom, $urandom};
      end else begin
        beat[15:0]  = sb.last_cnt[0] + 16'(int'($urandom_range(80)) - 30);
        beat[31:16] = sb.last_cnt[1] + 16'(int'($urandom_range(80)) - 30);
        beat[47:32] = t_l;
        beat[63:48] = t_r;
      end
      send_tick(beat);
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    hold_off = 1'b0;
    cycle_cnt = 0;
    src_idle_pct = 8;
    snk_idle_pct = 62;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset gains, field extremes, wraps and both directions
    send_tick(64'h0000_0000_0000_0000);
    send_tick(64'h7FFF_8000_0064_0064);
    send_tick(64'h8000_7FFF_FF9C_FF9C);
    send_tick(64'h0000_0000_0010_0010);
    send_tick(64'hFFFF_FFFF_FFF0_FFF0);
    send_tick(64'h1234_5678_FFFF_0001);
    send_tick(64'h0000_0000_0000_0000);
    wait_drained();

    // Zero drive limit and zero travel per pulse
    write_cfg(CFG_DLIM, 47'd0);
    write_cfg(CFG_MPP, 47'd0);
    send_tick(64'h7FFF_8000_0100_0100);
    send_tick(64'h8000_7FFF_0200_0200);
    wait_drained();

    // Largest gains and limits: speed saturation and output clamping
    write_cfg(CFG_KP, 47'hFF_FFFF);
    write_cfg(CFG_KI, 47'hFF_FFFF);
    write_cfg(CFG_KD, 47'hFF_FFFF);
    write_cfg(CFG_DLIM, 47'd1023);
    write_cfg(CFG_ILIM, 47'h7FFF_FFFF_FFFF);
    write_cfg(CFG_MPP, 47'hFFFF);
    send_tick(64'h8000_8000_7FFF_8000);
    send_tick(64'h0000_0000_8000_7FFF);
    send_tick(64'h7FFF_7FFF_0000_0000);
    send_tick(64'h0001_0001_0000_0000);
    wait_drained();

    // Small gains: drives between -1 and 0 cut to forward
    write_cfg(CFG_KP, 47'd1);
    write_cfg(CFG_KI, 47'd0);
    write_cfg(CFG_KD, 47'd0);
    write_cfg(CFG_ILIM, 47'd0);
    write_cfg(CFG_MPP, 47'd8579);
    send_tick(64'hFFFF_FFFF_0000_0000);
    send_tick(64'hFFFF_FFFF_0001_FFFF);
    wait_drained();

    // Random phase one at reset-like gains, sender rarely idle
    write_cfg(CFG_KP, 47'd32768);
    write_cfg(CFG_KI, 47'd6554);
    write_cfg(CFG_KD, 47'd1311);
    write_cfg(CFG_DLIM, 47'd999);
    write_cfg(CFG_ILIM, 47'd655360000);
    send_random(170);
    wait_drained();

    // Phase two: random registers, receiver rarely idle
    src_idle_pct = 62;
    snk_idle_pct = 8;
    write_cfg(CFG_KP, 47'($urandom_range(24'hFFFFFF)));
    write_cfg(CFG_KI, 47'($urandom_range(24'h3FFFF)));
    write_cfg(CFG_KD, 47'($urandom_range(24'h3FFFF)));
    write_cfg(CFG_DLIM, 47'($urandom_range(1023)));
    write_cfg(CFG_ILIM, {15'($urandom), 32'($urandom)});
    write_cfg(CFG_MPP, 47'($urandom_range(16'hFFFF)));
    send_random(160);
    wait_drained();

    // Phase three: no idling, with a long receiver hold-off to fill the block
    src_idle_pct = 0;
    snk_idle_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        for (hold_cnt = 0; hold_cnt < 1500; hold_cnt++) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      begin
        send_random(170);
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
    join
    wait_drained();

    if (sb.n_fail == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
